// ===== hw/rtl/cbe_pkg.sv =====
// ----------------------------------------------------------------------------
// cbe_pkg: shared types and constants for the cubic Bezier easing block
// Fixed point formats, pipeline word layouts and the result kind codes.
// ----------------------------------------------------------------------------
package cbe_pkg;

    // Fraction bits of progress, x and y, and of the curve parameter.
    localparam int FRAC_BITS = 16;
    localparam int UFRAC     = 32;
    localparam int TIME_W    = 32;
    localparam int DUR_W     = 32;
    localparam int CX_W      = 17;
    localparam int CY_W      = 20;
    localparam int OUT_W     = 20;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_DURATION = 3'd0;
    localparam logic [2:0] REG_CTRL_X1  = 3'd1;
    localparam logic [2:0] REG_CTRL_Y1  = 3'd2;
    localparam logic [2:0] REG_CTRL_X2  = 3'd3;
    localparam logic [2:0] REG_CTRL_Y2  = 3'd4;

    // How the final value of a word is formed.
    typedef enum logic [1:0] {
        K_CURVE = 2'd0,
        K_ZERO  = 2'd1,
        K_ONE   = 2'd2
    } t_kind;

    // Word moving through the divider cells.
    typedef struct packed {
        logic [DUR_W-1:0]     r;
        logic [DUR_W-1:0]     d;
        logic [FRAC_BITS-1:0] q;
        logic                 one;
    } t_div;

    // Word moving through the bisection cells: bracket [lo, hi] in Q1.32.
    typedef struct packed {
        logic [UFRAC:0]   lo;
        logic [UFRAC:0]   hi;
        logic [UFRAC-1:0] target;
        t_kind            kind;
    } t_bis;

    // Bernstein weights in Q3.32 (w1, w2) and Q1.32 (w3): w1 = 3(1-u)^2 u, w2 = 3(1-u)u^2, w3 = u^3.
    typedef struct packed {
        logic [UFRAC+2:0] w1;
        logic [UFRAC+2:0] w2;
        logic [UFRAC:0]   w3;
    } t_wts;

endpackage

// ===== hw/rtl/cbe_div_cell.sv =====
// ----------------------------------------------------------------------------
// cbe_div_cell: one step of the progress divider
// Produces one quotient bit per cell by restoring division.
// ----------------------------------------------------------------------------
module cbe_div_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  cbe_pkg::t_div  i_word,
    output logic           o_valid,
    output cbe_pkg::t_div  o_word
);

    logic                    r_valid;
    cbe_pkg::t_div           r_word;
    cbe_pkg::t_div           n_word;
    logic [cbe_pkg::DUR_W:0] rem2;
    logic                    ge;

    // Shift the remainder and subtract the divisor where it fits.
    always_comb begin
        rem2   = {i_word.r, 1'b0};
        ge     = rem2 >= {1'b0, i_word.d};
        n_word = i_word;
        n_word.q = {i_word.q[cbe_pkg::FRAC_BITS-2:0], ge};
        if (ge) begin
            n_word.r = cbe_pkg::DUR_W'(rem2 - {1'b0, i_word.d});
        end else begin
            n_word.r = rem2[cbe_pkg::DUR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_word <= n_word;
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// ===== hw/rtl/cbe_weights.sv =====
// ----------------------------------------------------------------------------
// cbe_weights: two stage Bernstein weight unit
// Computes the three cubic weights of u in Q0.32 and carries a word along.
// ----------------------------------------------------------------------------
module cbe_weights (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [cbe_pkg::UFRAC-1:0]     i_u,
    input  cbe_pkg::t_bis                 i_word,
    output logic                          o_valid,
    output cbe_pkg::t_wts                 o_wts,
    output cbe_pkg::t_bis                 o_word
);

    localparam int PW = 2 * cbe_pkg::UFRAC + 2;

    logic [cbe_pkg::UFRAC:0]   om;
    logic [cbe_pkg::UFRAC:0]   uu;
    logic [PW-1:0]             p_oo;
    logic [PW-1:0]             p_ou;
    logic [PW-1:0]             p_uu;
    logic [PW-1:0]             p_a;
    logic [PW-1:0]             p_b;
    logic [PW-1:0]             p_c;
    logic [cbe_pkg::UFRAC:0]   q_a;
    logic [cbe_pkg::UFRAC:0]   q_b;

    logic                      r_valid1;
    logic [cbe_pkg::UFRAC:0]   r_a;
    logic [cbe_pkg::UFRAC:0]   r_b;
    logic [cbe_pkg::UFRAC:0]   r_c;
    logic [cbe_pkg::UFRAC:0]   r_u;
    cbe_pkg::t_bis             r_word1;
    logic                      r_valid2;
    cbe_pkg::t_wts             r_wts;
    cbe_pkg::t_bis             r_word2;
    cbe_pkg::t_wts             n_wts;

    // First stage: (1-u)^2, (1-u)u and u^2, each floored to 32 fraction bits.
    always_comb begin
        uu   = {1'b0, i_u};
        om   = {1'b1, {cbe_pkg::UFRAC{1'b0}}} - uu;
        p_oo = om * om;
        p_ou = om * uu;
        p_uu = uu * uu;
    end

    // Second stage: multiply each by u once more and apply the factor three.
    always_comb begin
        p_a = r_a * r_u;
        p_b = r_b * r_u;
        p_c = r_c * r_u;
        q_a = p_a[2*cbe_pkg::UFRAC:cbe_pkg::UFRAC];
        q_b = p_b[2*cbe_pkg::UFRAC:cbe_pkg::UFRAC];
        n_wts.w1 = {2'b00, q_a} + {1'b0, q_a, 1'b0};
        n_wts.w2 = {2'b00, q_b} + {1'b0, q_b, 1'b0};
        n_wts.w3 = p_c[2*cbe_pkg::UFRAC:cbe_pkg::UFRAC];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
            r_valid2 <= 1'b0;
        end else begin
            r_valid1 <= i_valid;
            r_valid2 <= r_valid1;
        end
        r_a     <= p_oo[2*cbe_pkg::UFRAC:cbe_pkg::UFRAC];
        r_b     <= p_ou[2*cbe_pkg::UFRAC:cbe_pkg::UFRAC];
        r_c     <= p_uu[2*cbe_pkg::UFRAC:cbe_pkg::UFRAC];
        r_u     <= uu;
        r_word1 <= i_word;
        r_wts   <= n_wts;
        r_word2 <= r_word1;
    end

    assign o_valid = r_valid2;
    assign o_wts   = r_wts;
    assign o_word  = r_word2;

endmodule

// ===== hw/rtl/cbe_bisect_cell.sv =====
// ----------------------------------------------------------------------------
// cbe_bisect_cell: one bisection step of the curve parameter
// Evaluates x at the bracket midpoint and halves the bracket, in four stages.
// ----------------------------------------------------------------------------
module cbe_bisect_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  cbe_pkg::t_bis                 i_word,
    input  logic [cbe_pkg::CX_W-1:0]      i_ctrl_x1,
    input  logic [cbe_pkg::CX_W-1:0]      i_ctrl_x2,
    output logic                          o_valid,
    output cbe_pkg::t_bis                 o_word
);

    localparam int WW = cbe_pkg::UFRAC + 3;
    localparam int PXW = WW + cbe_pkg::CX_W;
    localparam int XW = PXW - cbe_pkg::FRAC_BITS + 1;

    logic [cbe_pkg::UFRAC+1:0] sum_in;
    logic [cbe_pkg::UFRAC+1:0] sum_out;
    logic [cbe_pkg::UFRAC:0]   mid;
    logic                      w_valid;
    cbe_pkg::t_wts             w_wts;
    cbe_pkg::t_bis             w_word;

    logic                      r_valid3;
    logic [PXW-1:0]            r_px1;
    logic [PXW-1:0]            r_px2;
    logic [cbe_pkg::UFRAC:0]   r_w3;
    cbe_pkg::t_bis             r_word3;
    logic                      r_valid4;
    cbe_pkg::t_bis             r_word4;
    cbe_pkg::t_bis             n_word4;
    logic [XW-1:0]             x_mid;

    // Midpoint of the incoming bracket feeds the weight unit.
    assign sum_in = {1'b0, i_word.lo} + {1'b0, i_word.hi};

    cbe_weights u_wts (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_u     (sum_in[cbe_pkg::UFRAC:1]),
        .i_word  (i_word),
        .o_valid (w_valid),
        .o_wts   (w_wts),
        .o_word  (w_word)
    );

    // Sum x(mid), compare against the target and move one bound.
    always_comb begin
        sum_out = {1'b0, r_word3.lo} + {1'b0, r_word3.hi};
        mid     = sum_out[cbe_pkg::UFRAC+1:1];
        x_mid   = XW'(r_px1[PXW-1:cbe_pkg::FRAC_BITS])
                + XW'(r_px2[PXW-1:cbe_pkg::FRAC_BITS])
                + XW'(r_w3);
        n_word4 = r_word3;
        if (XW'(r_word3.target) < x_mid) begin
            n_word4.hi = mid;
        end else begin
            n_word4.lo = mid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid3 <= 1'b0;
            r_valid4 <= 1'b0;
        end else begin
            r_valid3 <= w_valid;
            r_valid4 <= r_valid3;
        end
        r_px1   <= w_wts.w1 * i_ctrl_x1;
        r_px2   <= w_wts.w2 * i_ctrl_x2;
        r_w3    <= w_wts.w3;
        r_word3 <= w_word;
        r_word4 <= n_word4;
    end

    assign o_valid = r_valid4;
    assign o_word  = r_word4;

endmodule

// ===== hw/rtl/cbe_y_out.sv =====
// ----------------------------------------------------------------------------
// cbe_y_out: output evaluation of y at the final bracket midpoint
// Weights, signed products, rounding, saturation and the output register.
// ----------------------------------------------------------------------------
module cbe_y_out (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  cbe_pkg::t_bis                      i_word,
    input  logic signed [cbe_pkg::CY_W-1:0]    i_ctrl_y1,
    input  logic signed [cbe_pkg::CY_W-1:0]    i_ctrl_y2,
    output logic                               o_valid,
    output logic signed [cbe_pkg::OUT_W-1:0]   o_value
);

    localparam int WW  = cbe_pkg::UFRAC + 3;
    localparam int PYW = WW + 1 + cbe_pkg::CY_W;
    localparam int TW  = PYW + 2;
    localparam int RW  = TW - cbe_pkg::UFRAC;
    localparam int LIM = 4 << cbe_pkg::FRAC_BITS;
    localparam int ONE = 1 << cbe_pkg::FRAC_BITS;

    logic [cbe_pkg::UFRAC+1:0]  sum_in;
    logic                       w_valid;
    cbe_pkg::t_wts              w_wts;
    cbe_pkg::t_bis              w_word;

    logic                       r_valid_p;
    logic signed [PYW-1:0]      r_py1;
    logic signed [PYW-1:0]      r_py2;
    logic [cbe_pkg::UFRAC:0]    r_w3;
    cbe_pkg::t_kind             r_kind;
    logic                       r_valid;
    logic signed [cbe_pkg::OUT_W-1:0] r_value;
    logic signed [cbe_pkg::OUT_W-1:0] n_value;
    logic signed [TW-1:0]       total;
    logic signed [RW-1:0]       rounded;

    assign sum_in = {1'b0, i_word.lo} + {1'b0, i_word.hi};

    cbe_weights u_wts (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_u     (sum_in[cbe_pkg::UFRAC:1]),
        .i_word  (i_word),
        .o_valid (w_valid),
        .o_wts   (w_wts),
        .o_word  (w_word)
    );

    // Exact sum at 48 fraction bits, rounded half up, then clamped to four.
    always_comb begin
        total = TW'(r_py1) + TW'(r_py2)
              + $signed(TW'({r_w3, {cbe_pkg::FRAC_BITS{1'b0}}}));
        total = total + $signed(TW'(64'd1 << (cbe_pkg::UFRAC - 1)));
        rounded = RW'(total >>> cbe_pkg::UFRAC);
        if (rounded > RW'(LIM)) begin
            rounded = RW'(LIM);
        end else if (rounded < -$signed(RW'(LIM))) begin
            rounded = -$signed(RW'(LIM));
        end
        case (r_kind)
            cbe_pkg::K_ZERO: n_value = '0;
            cbe_pkg::K_ONE:  n_value = cbe_pkg::OUT_W'(ONE);
            default:         n_value = rounded[cbe_pkg::OUT_W-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_p <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_valid_p <= w_valid;
            r_valid   <= r_valid_p;
        end
        r_py1   <= $signed({1'b0, w_wts.w1}) * i_ctrl_y1;
        r_py2   <= $signed({1'b0, w_wts.w2}) * i_ctrl_y2;
        r_w3    <= w_wts.w3;
        r_kind  <= w_word.kind;
        r_value <= n_value;
    end

    assign o_valid = r_valid;
    assign o_value = r_value;

endmodule

// ===== hw/rtl/cubic_bezier_easing_top.sv =====
// ----------------------------------------------------------------------------
// cubic_bezier_easing_top: cubic Bezier easing curve evaluator
// Turns an elapsed time into an eased progress value through a divider chain
// and a chain of bisection cells.
// ----------------------------------------------------------------------------
// The block takes one word per clock cycle and never asserts busy. Each word
// returns its result on o_eased_value, marked by o_valid for one cycle,
// after one entry stage, 16 divider cells, four stages in each bisection
// cell (BISECT_STEPS cells, 30 by default) and four stages of output
// evaluation. Results come out in input order and cannot be stalled, so
// the receiver must take every o_valid cycle. Configuration may be written
// only while no word is in flight.
module cubic_bezier_easing_top #(
    parameter int BISECT_STEPS = 30
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [cbe_pkg::TIME_W-1:0]         i_elapsed_time,
    input  logic                               i_cfg_we,
    input  logic [2:0]                         i_cfg_idx,
    input  logic [cbe_pkg::DUR_W-1:0]          i_cfg_wdata,
    output logic                               o_valid,
    output logic signed [cbe_pkg::OUT_W-1:0]   o_eased_value
);

    localparam int NDIV = cbe_pkg::FRAC_BITS;

    logic [cbe_pkg::DUR_W-1:0]        r_duration;
    logic [cbe_pkg::CX_W-1:0]         r_ctrl_x1;
    logic signed [cbe_pkg::CY_W-1:0]  r_ctrl_y1;
    logic [cbe_pkg::CX_W-1:0]         r_ctrl_x2;
    logic signed [cbe_pkg::CY_W-1:0]  r_ctrl_y2;

    logic                             r_valid_in;
    cbe_pkg::t_div                    r_div_in;
    cbe_pkg::t_div                    n_div_in;
    logic [cbe_pkg::DUR_W-1:0]        d_eff;

    logic                             div_valid [NDIV+1];
    cbe_pkg::t_div                    div_word  [NDIV+1];
    logic                             bis_valid [BISECT_STEPS+1];
    cbe_pkg::t_bis                    bis_word  [BISECT_STEPS+1];

    assign busy = 1'b0;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duration <= cbe_pkg::DUR_W'(1);
            r_ctrl_x1  <= cbe_pkg::CX_W'(16384);
            r_ctrl_y1  <= '0;
            r_ctrl_x2  <= cbe_pkg::CX_W'(49152);
            r_ctrl_y2  <= cbe_pkg::CY_W'(65536);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cbe_pkg::REG_DURATION: r_duration <= i_cfg_wdata;
                cbe_pkg::REG_CTRL_X1:  r_ctrl_x1 <= i_cfg_wdata[cbe_pkg::CX_W-1:0];
                cbe_pkg::REG_CTRL_Y1:  r_ctrl_y1 <= i_cfg_wdata[cbe_pkg::CY_W-1:0];
                cbe_pkg::REG_CTRL_X2:  r_ctrl_x2 <= i_cfg_wdata[cbe_pkg::CX_W-1:0];
                cbe_pkg::REG_CTRL_Y2:  r_ctrl_y2 <= i_cfg_wdata[cbe_pkg::CY_W-1:0];
                default: ;
            endcase
        end
    end

    // Entry stage: zero duration counts as one, and flag progress at the end.
    always_comb begin
        d_eff        = (r_duration == '0) ? cbe_pkg::DUR_W'(1) : r_duration;
        n_div_in.r   = i_elapsed_time;
        n_div_in.d   = d_eff;
        n_div_in.q   = '0;
        n_div_in.one = i_elapsed_time >= d_eff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_in <= 1'b0;
        end else begin
            r_valid_in <= start & ~busy;
        end
        r_div_in <= n_div_in;
    end

    assign div_valid[0] = r_valid_in;
    assign div_word[0]  = r_div_in;

    // Divider chain: one quotient bit per cell.
    for (genvar g = 0; g < NDIV; g++) begin : g_div
        cbe_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (div_valid[g]),
            .i_word  (div_word[g]),
            .o_valid (div_valid[g+1]),
            .o_word  (div_word[g+1])
        );
    end

    // Start the bracket at [0, 1] with the progress as target, and set the result kind.
    always_comb begin
        bis_valid[0]        = div_valid[NDIV];
        bis_word[0].lo      = '0;
        bis_word[0].hi      = {1'b1, {cbe_pkg::UFRAC{1'b0}}};
        bis_word[0].target  = {div_word[NDIV].q,
                               {(cbe_pkg::UFRAC-cbe_pkg::FRAC_BITS){1'b0}}};
        if (div_word[NDIV].one) begin
            bis_word[0].kind = cbe_pkg::K_ONE;
        end else if (div_word[NDIV].q == '0) begin
            bis_word[0].kind = cbe_pkg::K_ZERO;
        end else begin
            bis_word[0].kind = cbe_pkg::K_CURVE;
        end
    end

    // Bisection chain: each cell halves the bracket once.
    for (genvar g = 0; g < BISECT_STEPS; g++) begin : g_bis
        cbe_bisect_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_valid   (bis_valid[g]),
            .i_word    (bis_word[g]),
            .i_ctrl_x1 (r_ctrl_x1),
            .i_ctrl_x2 (r_ctrl_x2),
            .o_valid   (bis_valid[g+1]),
            .o_word    (bis_word[g+1])
        );
    end

    cbe_y_out u_yout (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (bis_valid[BISECT_STEPS]),
        .i_word    (bis_word[BISECT_STEPS]),
        .i_ctrl_y1 (r_ctrl_y1),
        .i_ctrl_y2 (r_ctrl_y2),
        .o_valid   (o_valid),
        .o_value   (o_eased_value)
    );

endmodule

// ===== hw/rtl/cbe_checker.sv =====
// ----------------------------------------------------------------------------
// cbe_checker: port level checks for the cubic Bezier easing block
// Watches latency, unmatched results, the zero time case and the output range.
// ----------------------------------------------------------------------------
module cbe_checker #(
    parameter int BISECT_STEPS = 30
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               start,
    input logic                               busy,
    input logic [cbe_pkg::TIME_W-1:0]         i_elapsed_time,
    input logic                               i_cfg_we,
    input logic [2:0]                         i_cfg_idx,
    input logic [cbe_pkg::DUR_W-1:0]          i_cfg_wdata,
    input logic                               o_valid,
    input logic signed [cbe_pkg::OUT_W-1:0]   o_eased_value
);

    localparam int LAT = 21 + 4 * BISECT_STEPS;

    // Every accepted word returns exactly after the fixed latency.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##LAT o_valid)
        else $error("accepted word did not return on time");

    // No word is emitted that was not accepted at the matching edge.
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT))
        else $error("word emitted without a matching start");

    // Zero elapsed time always eases to zero.
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && $past(i_elapsed_time, LAT) == '0 |-> o_eased_value == '0)
        else $error("zero time did not give zero");

    // Results stay within plus or minus four.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_eased_value <= 20'sd262144 && o_eased_value >= -20'sd262144)
        else $error("eased value out of range");

endmodule

bind cubic_bezier_easing_top cbe_checker #(.BISECT_STEPS(BISECT_STEPS)) u_cbe_checker (.*);

// ===== test/cubic_bezier_easing_checker.sv =====
// ----------------------------------------------------------------------------
// cubic_bezier_easing_checker: result predictor and comparator
// Watches the start, configuration and result ports of the easing block,
// computes the eased value of every accepted word and compares in order.
// ----------------------------------------------------------------------------
module cubic_bezier_easing_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    input  logic                             busy,
    input  logic [cbe_pkg::TIME_W-1:0]       i_elapsed_time,
    input  logic                             i_cfg_we,
    input  logic [2:0]                       i_cfg_idx,
    input  logic [cbe_pkg::DUR_W-1:0]        i_cfg_wdata,
    input  logic                             o_valid,
    input  logic signed [cbe_pkg::OUT_W-1:0] o_eased_value,
    output int                               o_fail_count,
    output int                               o_pending,
    output int                               o_checked
);

    localparam int STEPS = 30;
    localparam logic [63:0] ONE_Q32 = 64'h1_0000_0000;

    // Shadow copy of the configuration registers.
    logic [31:0]        dur_reg;
    logic [16:0]        x1_reg, x2_reg;
    logic signed [19:0] y1_reg, y2_reg;

    logic [cbe_pkg::OUT_W-1:0] eased_queue[$];

    // Product of two Q0.32 fractions, floored; one operand may be exactly 1.0.
    function automatic logic [63:0] frac_mul(input logic [63:0] a, input logic [63:0] b);
        if (a >= ONE_Q32) return b;
        if (b >= ONE_Q32) return a;
        return (a * b) >> 32;
    endfunction

    function automatic void bernstein(input logic [63:0] u, output logic [63:0] w1,
                                      output logic [63:0] w2, output logic [63:0] w3);
        logic [63:0] om;
        om = ONE_Q32 - u;
        w1 = 3 * frac_mul(frac_mul(om, om), u);
        w2 = 3 * frac_mul(frac_mul(om, u), u);
        w3 = frac_mul(frac_mul(u, u), u);
    endfunction

    function automatic logic [cbe_pkg::OUT_W-1:0] eased_of(input logic [31:0] t);
        logic [63:0] d, p, target, lo, hi, mid, w1, w2, w3, xv;
        logic signed [63:0] total, res;
        logic [63:0] biased;
        d = (dur_reg == 0) ? 64'd1 : {32'd0, dur_reg};
        if ({32'd0, t} >= d) return cbe_pkg::OUT_W'(1 << cbe_pkg::FRAC_BITS);
        p = ({32'd0, t} << cbe_pkg::FRAC_BITS) / d;
        if (p == 0) return '0;
        target = p << (32 - cbe_pkg::FRAC_BITS);
        lo = 0;
        hi = ONE_Q32;
        for (int i = 0; i < STEPS; i++) begin
            mid = (lo + hi) >> 1;
            bernstein(mid, w1, w2, w3);
            xv = ((w1 * x1_reg) >> cbe_pkg::FRAC_BITS)
               + ((w2 * x2_reg) >> cbe_pkg::FRAC_BITS) + w3;
            if (target < xv) hi = mid;
            else lo = mid;
        end
        bernstein((lo + hi) >> 1, w1, w2, w3);
        total = $signed(w1) * 64'(y1_reg) + $signed(w2) * 64'(y2_reg)
              + $signed(w3 << cbe_pkg::FRAC_BITS);
        biased = total + (64'd1 << 63) + (64'd1 << 31);
        res = $signed(biased >> 32) - (64'sd1 <<< 31);
        if (res > (64'sd4 <<< cbe_pkg::FRAC_BITS)) res = 64'sd4 <<< cbe_pkg::FRAC_BITS;
        if (res < -(64'sd4 <<< cbe_pkg::FRAC_BITS)) res = -(64'sd4 <<< cbe_pkg::FRAC_BITS);
        return res[cbe_pkg::OUT_W-1:0];
    endfunction

    // Configuration writes, accepted words and results, all seen at the clock edge.
    always @(posedge i_clk) begin
        logic [cbe_pkg::OUT_W-1:0] want;
        if (!i_rst_n) begin
            dur_reg <= 32'd1;
            x1_reg  <= 17'd16384;
            y1_reg  <= '0;
            x2_reg  <= 17'd49152;
            y2_reg  <= 20'sd65536;
            eased_queue.delete();
            o_fail_count <= 0;
            o_checked <= 0;
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    cbe_pkg::REG_DURATION: dur_reg <= i_cfg_wdata;
                    cbe_pkg::REG_CTRL_X1:  x1_reg  <= i_cfg_wdata[16:0];
                    cbe_pkg::REG_CTRL_Y1:  y1_reg  <= i_cfg_wdata[19:0];
                    cbe_pkg::REG_CTRL_X2:  x2_reg  <= i_cfg_wdata[16:0];
                    cbe_pkg::REG_CTRL_Y2:  y2_reg  <= i_cfg_wdata[19:0];
                    default: ;
                endcase
            end
            if (start && !busy) eased_queue.push_back(eased_of(i_elapsed_time));
            if (o_valid) begin
                o_checked <= o_checked + 1;
                if (eased_queue.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual %0d",
                             $time, o_eased_value);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = eased_queue.pop_front();
                    if (want !== o_eased_value) begin
                        $display("%0t: eased_value mismatch, expected %0d, actual %0d",
                                 $time, $signed(want), o_eased_value);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            o_pending <= eased_queue.size();
        end
    end

endmodule

// ===== test/cubic_bezier_easing_top_tb.sv =====
// ----------------------------------------------------------------------------
// cubic_bezier_easing_top_tb: stimulus and verdict for the easing block
// Runs phases of configuration, directed and random elapsed times, mostly with random
// gaps; a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module cubic_bezier_easing_top_tb;

    localparam int LATENCY = 141;
    localparam int LIMIT   = 2000000;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             start = 1'b0;
    logic                             busy;
    logic [cbe_pkg::TIME_W-1:0]       i_elapsed_time = '0;
    logic                             i_cfg_we = 1'b0;
    logic [2:0]                       i_cfg_idx = cbe_pkg::REG_DURATION;
    logic [cbe_pkg::DUR_W-1:0]        i_cfg_wdata = '0;
    logic                             o_valid;
    logic signed [cbe_pkg::OUT_W-1:0] o_eased_value;
    int fail_count, pending, checked;
    int cycle_count = 0;
    int words_sent = 0;
    bit no_gaps = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    cubic_bezier_easing_top dut (.*);

    cubic_bezier_easing_checker checker_i (
        .i_clk, .i_rst_n, .start, .busy, .i_elapsed_time, .i_cfg_we, .i_cfg_idx,
        .i_cfg_wdata, .o_valid, .o_eased_value,
        .o_fail_count(fail_count), .o_pending(pending), .o_checked(checked)
    );

    // Watchdog on total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("cubic_bezier_easing_top_tb failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_curve(input logic [31:0] dur, input logic [16:0] x1,
                             input logic signed [19:0] y1, input logic [16:0] x2,
                             input logic signed [19:0] y2);
        write_reg(cbe_pkg::REG_DURATION, dur);
        write_reg(cbe_pkg::REG_CTRL_X1, {15'd0, x1});
        write_reg(cbe_pkg::REG_CTRL_Y1, {{12{y1[19]}}, y1});
        write_reg(cbe_pkg::REG_CTRL_X2, {15'd0, x2});
        write_reg(cbe_pkg::REG_CTRL_Y2, {{12{y2[19]}}, y2});
    endtask

    // Send one word, with a random gap unless gaps are switched off.
    task automatic send_time(input logic [31:0] t);
        while (!no_gaps && $urandom_range(99) < 30) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_elapsed_time <= t;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic drain;
        start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    // Elapsed time biased toward the interesting span below the duration.
    function automatic logic [31:0] rand_time(input logic [31:0] dur);
        case ($urandom_range(9))
            0: return $urandom;
            1: return dur - $urandom_range(3);
            2: return $urandom_range(3);
            default: return (dur <= 1) ? $urandom_range(1) : $urandom_range(dur - 1);
        endcase
    endfunction

    task automatic random_phase(input int count);
        for (int i = 0; i < count; i++) send_time(rand_time(checker_i.dur_reg));
        drain();
    endtask

    initial begin
        logic [31:0] dur;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset curve with duration 1, then a standard curve.
        send_time(32'd0);
        send_time(32'd1);
        send_time(32'hFFFF_FFFF);
        drain();
        set_curve(32'd1000, 17'd16384, 20'sd6554, 17'd16384, 20'sd65536);
        send_time(32'd0);
        send_time(32'd1);
        send_time(32'd15);
        send_time(32'd16);
        send_time(32'd500);
        send_time(32'd999);
        send_time(32'd1000);
        send_time(32'd1001);
        send_time(32'hFFFF_FFFF);
        drain();
        // Extreme controls: overshoot and saturation, zero duration, max duration.
        set_curve(32'd0, 17'h1FFFF, 20'sh7FFFF, 17'd0, 20'sh80000);
        send_time(32'd0);
        send_time(32'd5);
        drain();
        set_curve(32'hFFFF_FFFF, 17'd0, 20'sd262144, 17'd65536, -20'sd262144);
        send_time(32'h0000_FFFF);
        send_time(32'h0001_0000);
        send_time(32'h8000_0000);
        send_time(32'hFFFF_FFFE);
        send_time(32'hAAAA_AAAA);
        send_time(32'h5555_5555);
        drain();

        // Random phases with random curves, one stretch without gaps.
        for (int ph = 0; ph < 12; ph++) begin
            dur = ($urandom_range(3) == 0) ? $urandom : $urandom_range(5000, 1);
            set_curve(dur, 17'($urandom_range(65536)),
                      20'($signed($urandom_range(524287)) - 262144),
                      17'($urandom_range(65536)),
                      20'($signed($urandom_range(524287)) - 262144));
            no_gaps = (ph == 5);
            random_phase(120);
        end
        no_gaps = 1'b0;

        $display("Sent %0d elapsed times over 16 curve settings; %0d results checked.",
                 words_sent, checked);
        if (fail_count == 0) begin
            $display("cubic_bezier_easing_top_tb passed");
        end else begin
            $display("cubic_bezier_easing_top_tb failed");
        end
        $finish;
    end

endmodule
